@@ rtl/shp_pkg.sv @@
// Shared types and constants for the substring polynomial hash core.
// Holds the Mersenne modulus, opcodes and status codes; no dependencies.
package shp_pkg;

   typedef logic [60:0] word_type;

   localparam word_type MOD_P      = 61'h1FFF_FFFF_FFFF_FFFF;
   // exponent P-2 for the Fermat inverse
   localparam word_type EXP_INV    = 61'h1FFF_FFFF_FFFF_FFFD;
   localparam word_type BASE_RESET = 61'd1000000007;
   localparam int       EXP_BITS   = 61;

   localparam logic [1:0] MODE_APPEND = 2'd0;
   localparam logic [1:0] MODE_QUERY  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

@@ rtl/shp_ram.sv @@
// Single-port-write, registered-read memory holding prefix sum and inverse power.
// Generic storage; no package dependency.
module shp_ram #(
   parameter int DEPTH = 4097,
   parameter int AW    = 13,
   parameter int W     = 122
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [W-1:0]  wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [W-1:0]  rd_data
);

   logic [W-1:0] mem [DEPTH];
   logic [W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/shp_mulmod.sv @@
// Multi-cycle 61x61 modular multiplier mod 2^61-1, one 32x32 partial product a cycle.
// Depends on shp_pkg for the word type and modulus.
module shp_mulmod import shp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     mul_start,
   input  word_type op_a,
   input  word_type op_b,
   output logic     mul_done,
   output word_type mul_result
);

   word_type     a_ff, b_ff, res_ff;
   logic [2:0]   cnt_ff;
   logic         run_ff, done_ff;
   logic [63:0]  pp_ff;
   logic [121:0] acc_ff;

   logic [31:0]  a_part, b_part;
   logic [63:0]  pp_in;
   logic [2:0]   sel;
   logic [121:0] addend;
   logic [61:0]  fold;
   word_type     fold2, red;

   // pick the halves for this step
   always_comb begin
      a_part = cnt_ff[1] ? {3'b000, a_ff[60:32]} : a_ff[31:0];
      b_part = cnt_ff[0] ? {3'b000, b_ff[60:32]} : b_ff[31:0];
      pp_in  = a_part * b_part;
   end

   // align the previous partial product
   always_comb begin
      sel = cnt_ff - 3'd1;
      case (sel[1:0])
         2'd0:    addend = {58'd0, pp_ff};
         2'd1,
         2'd2:    addend = {58'd0, pp_ff} << 32;
         default: addend = {58'd0, pp_ff} << 64;
      endcase
   end

   // fold the 122-bit product twice
   always_comb begin
      fold  = {1'b0, acc_ff[60:0]} + {1'b0, acc_ff[121:61]};
      fold2 = fold[60:0] + {60'd0, fold[61]};
      red   = (fold2 == MOD_P) ? '0 : fold2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mul_start) begin
            a_ff   <= op_a;
            b_ff   <= op_b;
            acc_ff <= '0;
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            if (cnt_ff <= 3'd3) begin
               pp_ff <= pp_in;
            end
            if (cnt_ff >= 3'd1 && cnt_ff <= 3'd4) begin
               acc_ff <= acc_ff + addend;
            end
            if (cnt_ff == 3'd5) begin
               res_ff  <= red;
               done_ff <= 1'b1;
               run_ff  <= 1'b0;
            end
            cnt_ff <= cnt_ff + 3'd1;
         end
      end
   end

   assign mul_done   = done_ff;
   assign mul_result = res_ff;

endmodule

@@ rtl/substring_polynomial_hash_core.sv @@
// Substring polynomial hash core, modulo 2^61-1; uses shp_pkg, shp_ram, shp_mulmod.
// One item at a time; busy is high while an item is in work. Every modular multiply
// runs in the shared shp_mulmod: append uses three, query one; clear, full append or
// bad range answer straight from idle. The first append after reset or a base write
// adds 121 multiplies for base^(P-2). Result strobes one cycle and cannot be stalled.
// Synchronous reset empties the string; no memory clearing pass.
module substring_polynomial_hash_core import shp_pkg::*; #(
   parameter int MAX_LENGTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_symbol,
   input  logic [12:0] req_query_start,
   input  logic [12:0] req_query_end,
   output logic        rsp_strobe,
   output logic [60:0] rsp_hash_value,
   output logic [1:0]  rsp_status,
   output logic [12:0] rsp_string_length,
   input  logic        csr_we,
   input  logic [60:0] csr_wdata
);

   localparam int DEPTH = MAX_LENGTH + 1;
   localparam int LW    = $clog2(DEPTH);
   localparam int CW    = (LW > 13) ? LW : 13;

   typedef enum logic [3:0] {
      S_IDLE, S_INV_A, S_INV_WA, S_INV_SQ, S_INV_WS,
      S_APP_RD, S_APP_RW, S_APP_M1, S_APP_M2, S_APP_M3,
      S_Q_RD1, S_Q_RD2, S_Q_RD3, S_Q_M
   } state_type;

   state_type   state_ff;
   logic [7:0]  sym_ff;
   logic [12:0] l_ff, r_ff;
   logic [LW-1:0] len_ff;
   word_type    rp_ff, base_ff, binv_ff, acc_ff, bb_ff;
   word_type    ps_old_ff, ip_old_ff, s_ff, ipn_ff, c_ff;
   logic        inv_rdy_ff;
   logic [5:0]  bit_ff;
   logic        mstart_ff;
   word_type    ma_ff, mb_ff;
   logic        rsp_strobe_ff;
   word_type    rsp_hash_ff;
   logic [1:0]  rsp_status_ff;
   logic [12:0] rsp_len_ff;

   logic        accept, full, bad_range;
   logic        mul_done;
   word_type    mul_result;
   logic [CW-1:0] len_cw, l_cw, r_cw, ql_cw, qr_cw, len_next_cw;
   logic [LW-1:0] rd_addr;
   logic        wr_en;
   logic [121:0] rd_data;
   word_type    rd_ps, rd_ip, app_t_sum, q_a;
   logic [61:0] sum_t, diff_t;
   word_type    csr_base;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   always_comb begin
      len_cw      = CW'(len_ff);
      len_next_cw = CW'(len_ff) + CW'(1);
      l_cw        = CW'(l_ff);
      r_cw        = CW'(r_ff);
      ql_cw       = CW'(req_query_start);
      qr_cw       = CW'(req_query_end);
      full        = (len_cw == CW'(MAX_LENGTH));
      bad_range   = (ql_cw > qr_cw) || (qr_cw > len_cw);
      csr_base    = (csr_wdata == MOD_P) ? '0 : csr_wdata;
   end

   // memory read address follows the sequencer
   always_comb begin
      case (state_ff)
         S_Q_RD1: rd_addr = l_cw[LW-1:0];
         S_Q_RD2: rd_addr = r_cw[LW-1:0];
         default: rd_addr = len_ff;
      endcase
   end

   assign rd_ps = rd_data[121:61];
   assign rd_ip = rd_data[60:0];
   assign wr_en = (state_ff == S_APP_M3) && mul_done;

   // prefix sum add and query difference, mod P
   always_comb begin
      sum_t     = {1'b0, ps_old_ff} + {1'b0, mul_result};
      app_t_sum = (sum_t >= {1'b0, MOD_P}) ? 61'(sum_t - {1'b0, MOD_P}) : sum_t[60:0];
      q_a       = (r_ff == 13'd0) ? '0 : rd_ps;
      diff_t    = (q_a >= c_ff) ? {1'b0, q_a} - {1'b0, c_ff}
                                : {1'b0, q_a} + {1'b0, MOD_P} - {1'b0, c_ff};
   end

   shp_ram #(.DEPTH(DEPTH), .AW(LW), .W(122)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_next_cw[LW-1:0]),
      .wr_data ({s_ff, ipn_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   shp_mulmod u_mul (
      .clock      (clock),
      .reset      (reset),
      .mul_start  (mstart_ff),
      .op_a       (ma_ff),
      .op_b       (mb_ff),
      .mul_done   (mul_done),
      .mul_result (mul_result)
   );

   // sequencer: state, stored scalars and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         len_ff        <= '0;
         rp_ff         <= 61'd1;
         base_ff       <= BASE_RESET;
         binv_ff       <= '0;
         inv_rdy_ff    <= 1'b0;
         mstart_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         mstart_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (csr_we) begin
                  base_ff    <= csr_base;
                  inv_rdy_ff <= 1'b0;
                  len_ff     <= '0;
                  rp_ff      <= 61'd1;
               end else if (accept) begin
                  sym_ff        <= req_symbol;
                  l_ff          <= req_query_start;
                  r_ff          <= req_query_end;
                  rsp_hash_ff   <= '0;
                  rsp_status_ff <= ST_OK;
                  rsp_len_ff    <= len_cw[12:0];
                  case (req_mode)
                     MODE_APPEND: begin
                        if (full) begin
                           rsp_status_ff <= ST_FULL;
                           rsp_strobe_ff <= 1'b1;
                        end else if (!inv_rdy_ff) begin
                           acc_ff   <= 61'd1;
                           bb_ff    <= base_ff;
                           bit_ff   <= '0;
                           state_ff <= S_INV_A;
                        end else begin
                           state_ff <= S_APP_RD;
                        end
                     end
                     MODE_QUERY: begin
                        if (bad_range) begin
                           rsp_status_ff <= ST_RANGE;
                           rsp_strobe_ff <= 1'b1;
                        end else begin
                           state_ff <= S_Q_RD1;
                        end
                     end
                     MODE_CLEAR: begin
                        len_ff        <= '0;
                        rp_ff         <= 61'd1;
                        rsp_len_ff    <= '0;
                        rsp_strobe_ff <= 1'b1;
                     end
                     default: begin
                        rsp_strobe_ff <= 1'b1;
                     end
                  endcase
               end
            end
            // square-and-multiply for base^(P-2), LSB first
            S_INV_A: begin
               if (EXP_INV[bit_ff]) begin
                  ma_ff     <= acc_ff;
                  mb_ff     <= bb_ff;
                  mstart_ff <= 1'b1;
                  state_ff  <= S_INV_WA;
               end else begin
                  state_ff <= S_INV_SQ;
               end
            end
            S_INV_WA: begin
               if (mul_done) begin
                  acc_ff   <= mul_result;
                  state_ff <= S_INV_SQ;
               end
            end
            S_INV_SQ: begin
               ma_ff     <= bb_ff;
               mb_ff     <= bb_ff;
               mstart_ff <= 1'b1;
               state_ff  <= S_INV_WS;
            end
            S_INV_WS: begin
               if (mul_done) begin
                  bb_ff <= mul_result;
                  if (bit_ff == 6'(EXP_BITS - 1)) begin
                     binv_ff    <= acc_ff;
                     inv_rdy_ff <= 1'b1;
                     state_ff   <= S_APP_RD;
                  end else begin
                     bit_ff   <= bit_ff + 6'd1;
                     state_ff <= S_INV_A;
                  end
               end
            end
            // append: read entry len, then three multiplies
            S_APP_RD: begin
               state_ff <= S_APP_RW;
            end
            S_APP_RW: begin
               ps_old_ff <= (len_ff == '0) ? '0 : rd_ps;
               ip_old_ff <= (len_ff == '0) ? 61'd1 : rd_ip;
               ma_ff     <= {53'd0, sym_ff};
               mb_ff     <= rp_ff;
               mstart_ff <= 1'b1;
               state_ff  <= S_APP_M1;
            end
            S_APP_M1: begin
               if (mul_done) begin
                  s_ff      <= app_t_sum;
                  ma_ff     <= ip_old_ff;
                  mb_ff     <= binv_ff;
                  mstart_ff <= 1'b1;
                  state_ff  <= S_APP_M2;
               end
            end
            S_APP_M2: begin
               if (mul_done) begin
                  ipn_ff    <= mul_result;
                  ma_ff     <= rp_ff;
                  mb_ff     <= base_ff;
                  mstart_ff <= 1'b1;
                  state_ff  <= S_APP_M3;
               end
            end
            S_APP_M3: begin
               // entry len+1 is written here; only a later item, after the return to idle, reads it
               if (mul_done) begin
                  rp_ff         <= mul_result;
                  len_ff        <= len_next_cw[LW-1:0];
                  rsp_len_ff    <= len_next_cw[12:0];
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            // query: read entry l, then entry r, then one multiply
            S_Q_RD1: begin
               state_ff <= S_Q_RD2;
            end
            S_Q_RD2: begin
               c_ff      <= (l_ff == 13'd0) ? '0 : rd_ps;
               ip_old_ff <= (l_ff == 13'd0) ? 61'd1 : rd_ip;
               state_ff  <= S_Q_RD3;
            end
            S_Q_RD3: begin
               ma_ff     <= diff_t[60:0];
               mb_ff     <= ip_old_ff;
               mstart_ff <= 1'b1;
               state_ff  <= S_Q_M;
            end
            S_Q_M: begin
               if (mul_done) begin
                  rsp_hash_ff   <= mul_result;
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_hash_value    = rsp_hash_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_string_length = rsp_len_ff;

   // a result always lands back in idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("result while busy");

   // non-ok status carries a zero hash
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> (rsp_hash_value == '0))
      else $error("error result with nonzero hash");

   // length never passes capacity
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      CW'(len_ff) <= CW'(MAX_LENGTH)) else $error("length overflow");

   // store write only on a finishing append
   a_wr_strobe: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (rsp_strobe && rsp_status == ST_OK)) else $error("write without result");

endmodule
